// ===== sv/mmb_pkg.sv =====
// Shared types and constants for the dense layer block.
package mmb_pkg;

    // Field widths of the command and result beats
    localparam int CMD_W     = 2;
    localparam int IDX_W     = 6;
    localparam int ELEM_W    = 16;
    localparam int BIAS_W    = 32;
    localparam int OUT_ROW_W = 4;
    localparam int RES_W     = 32;
    localparam int PROD_W    = 2 * ELEM_W;
    localparam int ACC_W     = 48;

    // Configuration register widths and APB port sizes
    localparam int ROWS_CFG_W = 5;
    localparam int DIM_CFG_W  = 7;
    localparam int APB_AW     = 4;
    localparam int APB_DW     = 32;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_LOAD_INPUT  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_LOAD_WEIGHT = 2'd1;
    localparam logic [CMD_W-1:0] CMD_LOAD_BIAS   = 2'd2;
    localparam logic [CMD_W-1:0] CMD_COMPUTE     = 2'd3;

    // Register indexes (byte address 4*index)
    localparam logic [1:0] REG_ROW_COUNT   = 2'd0;
    localparam logic [1:0] REG_IN_WIDTH    = 2'd1;
    localparam logic [1:0] REG_OUT_WIDTH   = 2'd2;
    localparam logic [1:0] REG_BIAS_ENABLE = 2'd3;

    // Result status codes
    localparam logic STATUS_OK    = 1'b0;
    localparam logic STATUS_RANGE = 1'b1;

    typedef struct packed {
        logic [ROWS_CFG_W-1:0] row_count;
        logic [DIM_CFG_W-1:0]  in_width;
        logic [DIM_CFG_W-1:0]  out_width;
        logic                  bias_enable;
    } cfg_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_DRAIN,
        ST_ERROR
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic wr_input;
        logic wr_weight;
        logic wr_bias;
        logic issue;
        logic issue_first;
        logic issue_last;
        logic result_load;
        logic result_last;
        logic err_load;
    } ctrl_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic acc_ready;
        logic out_free;
    } dp_status_t;

endpackage

// ===== sv/mmb_if.sv =====
// Command and result channel interfaces.
interface mmb_cmd_if import mmb_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [CMD_W-1:0]         command;
    logic [IDX_W-1:0]         row_index;
    logic [IDX_W-1:0]         col_index;
    logic signed [ELEM_W-1:0] element_value;
    logic signed [BIAS_W-1:0] bias_value;

    modport source (
        output valid, command, row_index, col_index, element_value, bias_value,
        input  ready
    );
    modport sink (
        input  valid, command, row_index, col_index, element_value, bias_value,
        output ready
    );
endinterface

interface mmb_res_if import mmb_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [OUT_ROW_W-1:0]    out_row;
    logic [IDX_W-1:0]        out_col;
    logic signed [RES_W-1:0] result_value;
    logic                    last;
    logic                    status;

    modport source (
        output valid, out_row, out_col, result_value, last, status,
        input  ready
    );
    modport sink (
        input  valid, out_row, out_col, result_value, last, status,
        output ready
    );
endinterface

// ===== sv/mmb_ram.sv =====
// Generic simple dual-port RAM with registered read.
module mmb_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // One write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/mmb_ctrl.sv =====
// Sequencer for loads and the column-by-column MAC schedule.
module mmb_ctrl
    import mmb_pkg::*;
#(
    parameter int MAX_ROWS = 16,
    parameter int MAX_IN   = 64,
    parameter int MAX_OUT  = 64,
    parameter int K_W      = (MAX_IN > 1) ? $clog2(MAX_IN) : 1
) (
    input  logic             clk,
    input  logic             rst_n,
    input  cfg_t             cfg,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [CMD_W-1:0] in_command,
    input  logic [IDX_W-1:0] in_row,
    input  dp_status_t       sts,
    output ctrl_cmd_t        cmd,
    output logic [K_W-1:0]   k,
    output logic [IDX_W-1:0] j,
    output logic [IDX_W-1:0] row
);

    state_t                state_reg, state_next;
    logic [K_W-1:0]        k_reg, k_next;
    logic [IDX_W-1:0]      j_reg, j_next;
    logic [IDX_W-1:0]      row_reg, row_next;
    logic [ROWS_CFG_W-1:0] nrows;
    logic [DIM_CFG_W-1:0]  nin_m1;
    logic [IDX_W-1:0]      nout_m1;
    logic                  accept;
    logic                  row_ok;
    logic                  k_last;
    logic                  j_last;

    // Effective dimensions, clamped to 1..max
    always_comb
    begin
        if (cfg.row_count == '0)
            nrows = ROWS_CFG_W'(1);
        else if (32'(cfg.row_count) > MAX_ROWS)
            nrows = ROWS_CFG_W'(MAX_ROWS);
        else
            nrows = cfg.row_count;

        if (cfg.in_width == '0)
            nin_m1 = '0;
        else if (32'(cfg.in_width) > MAX_IN)
            nin_m1 = DIM_CFG_W'(MAX_IN - 1);
        else
            nin_m1 = cfg.in_width - DIM_CFG_W'(1);

        if (cfg.out_width == '0)
            nout_m1 = '0;
        else if (32'(cfg.out_width) > MAX_OUT)
            nout_m1 = IDX_W'(MAX_OUT - 1);
        else
            nout_m1 = IDX_W'(cfg.out_width - DIM_CFG_W'(1));
    end

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;
    assign row_ok   = (32'(in_row) < 32'(nrows));
    assign k_last   = (32'(k_reg) == 32'(nin_m1));
    assign j_last   = (j_reg == nout_m1);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && in_command == CMD_COMPUTE)
                    state_next = row_ok ? ST_ISSUE : ST_ERROR;
            end
            ST_ISSUE:
            begin
                if (k_last)
                    state_next = ST_DRAIN;
            end
            ST_DRAIN:
            begin
                if (sts.acc_ready && sts.out_free)
                    state_next = j_last ? ST_IDLE : ST_ISSUE;
            end
            ST_ERROR:
            begin
                if (sts.out_free)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Commands to the datapath
    always_comb
    begin
        cmd = '0;
        case (state_reg)
            ST_IDLE:
            begin
                cmd.wr_input  = accept && (in_command == CMD_LOAD_INPUT);
                cmd.wr_weight = accept && (in_command == CMD_LOAD_WEIGHT);
                cmd.wr_bias   = accept && (in_command == CMD_LOAD_BIAS);
            end
            ST_ISSUE:
            begin
                cmd.issue       = 1'b1;
                cmd.issue_first = (k_reg == '0);
                cmd.issue_last  = k_last;
            end
            ST_DRAIN:
            begin
                cmd.result_load = sts.acc_ready && sts.out_free;
                cmd.result_last = j_last;
            end
            ST_ERROR:
            begin
                cmd.err_load = sts.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    // Row latch and k/j counters
    always_comb
    begin
        k_next   = k_reg;
        j_next   = j_reg;
        row_next = row_reg;
        if (state_reg == ST_IDLE && accept && in_command == CMD_COMPUTE)
        begin
            row_next = in_row;
            k_next   = '0;
            j_next   = '0;
        end
        else if (state_reg == ST_ISSUE && !k_last)
        begin
            k_next = k_reg + K_W'(1);
        end
        else if (cmd.result_load)
        begin
            k_next = '0;
            j_next = j_reg + IDX_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            k_reg     <= '0;
            j_reg     <= '0;
            row_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            k_reg     <= k_next;
            j_reg     <= j_next;
            row_reg   <= row_next;
        end
    end

    assign k   = k_reg;
    assign j   = j_reg;
    assign row = row_reg;

endmodule

// ===== sv/mmb_dp.sv =====
// Stores, MAC pipeline, saturation and output register.
module mmb_dp
    import mmb_pkg::*;
#(
    parameter int MAX_ROWS = 16,
    parameter int MAX_IN   = 64,
    parameter int MAX_OUT  = 64,
    parameter int K_W      = (MAX_IN > 1) ? $clog2(MAX_IN) : 1
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  ctrl_cmd_t                cmd,
    input  logic [K_W-1:0]           k,
    input  logic [IDX_W-1:0]         j,
    input  logic [IDX_W-1:0]         row,
    input  logic                     bias_enable,
    input  logic [IDX_W-1:0]         in_row,
    input  logic [IDX_W-1:0]         in_col,
    input  logic signed [ELEM_W-1:0] in_element,
    input  logic signed [BIAS_W-1:0] in_bias,
    output dp_status_t               sts,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [OUT_ROW_W-1:0]     out_row,
    output logic [IDX_W-1:0]         out_col,
    output logic signed [RES_W-1:0]  out_result,
    output logic                     out_last,
    output logic                     out_status
);

    localparam int IN_DEPTH = MAX_ROWS * MAX_IN;
    localparam int W_DEPTH  = MAX_IN * MAX_OUT;
    localparam int IN_AW    = (IN_DEPTH > 1) ? $clog2(IN_DEPTH) : 1;
    localparam int W_AW     = (W_DEPTH > 1) ? $clog2(W_DEPTH) : 1;
    localparam int B_AW     = (MAX_OUT > 1) ? $clog2(MAX_OUT) : 1;

    logic [IN_AW-1:0]         in_waddr, in_raddr;
    logic [W_AW-1:0]          w_waddr, w_raddr;
    logic [B_AW-1:0]          b_waddr, b_raddr;
    logic                     in_we, w_we, b_we;
    logic [ELEM_W-1:0]        a_rd, w_rd;
    logic [BIAS_W-1:0]        b_rd;

    logic                     s1_valid_reg, s1_first_reg, s1_last_reg;
    logic                     s2_valid_reg, s2_first_reg, s2_last_reg;
    logic signed [PROD_W-1:0] p_reg;
    logic signed [ACC_W-1:0]  init_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  p_ext;
    logic                     acc_ready_reg;
    logic [RES_W-1:0]         sat_value;

    logic                     out_valid_reg;
    logic [OUT_ROW_W-1:0]     out_row_reg;
    logic [IDX_W-1:0]         out_col_reg;
    logic [RES_W-1:0]         out_result_reg;
    logic                     out_last_reg;
    logic                     out_status_reg;
    logic                     out_free;

    // Load addresses with range checks against the store shapes
    assign in_we = cmd.wr_input && (32'(in_row) < MAX_ROWS) && (32'(in_col) < MAX_IN);
    assign w_we  = cmd.wr_weight && (32'(in_row) < MAX_IN) && (32'(in_col) < MAX_OUT);
    assign b_we  = cmd.wr_bias && (32'(in_col) < MAX_OUT);

    assign in_waddr = IN_AW'(32'(in_row) * MAX_IN + 32'(in_col));
    assign w_waddr  = W_AW'(32'(in_row) * MAX_OUT + 32'(in_col));
    assign b_waddr  = B_AW'(in_col);

    // Read addresses: input[row][k], weight[k][j], bias[j]
    assign in_raddr = IN_AW'(32'(row) * MAX_IN + 32'(k));
    assign w_raddr  = W_AW'(32'(k) * MAX_OUT + 32'(j));
    assign b_raddr  = B_AW'(j);

    mmb_ram #(.WIDTH(ELEM_W), .DEPTH(IN_DEPTH)) u_input_ram (
        .clk   (clk),
        .we    (in_we),
        .waddr (in_waddr),
        .wdata (in_element),
        .raddr (in_raddr),
        .rdata (a_rd)
    );

    mmb_ram #(.WIDTH(ELEM_W), .DEPTH(W_DEPTH)) u_weight_ram (
        .clk   (clk),
        .we    (w_we),
        .waddr (w_waddr),
        .wdata (in_element),
        .raddr (w_raddr),
        .rdata (w_rd)
    );

    mmb_ram #(.WIDTH(BIAS_W), .DEPTH(MAX_OUT)) u_bias_ram (
        .clk   (clk),
        .we    (b_we),
        .waddr (b_waddr),
        .wdata (in_bias),
        .raddr (b_raddr),
        .rdata (b_rd)
    );

    // Pipeline tags: read -> multiply -> accumulate
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s1_first_reg  <= 1'b0;
            s1_last_reg   <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s2_first_reg  <= 1'b0;
            s2_last_reg   <= 1'b0;
            acc_ready_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= cmd.issue;
            s1_first_reg <= cmd.issue_first;
            s1_last_reg  <= cmd.issue_last;
            s2_valid_reg <= s1_valid_reg;
            s2_first_reg <= s1_first_reg;
            s2_last_reg  <= s1_last_reg;
            if (cmd.result_load)
                acc_ready_reg <= 1'b0;
            else if (s2_valid_reg && s2_last_reg)
                acc_ready_reg <= 1'b1;
        end
    end

    assign p_ext = {{(ACC_W-PROD_W){p_reg[PROD_W-1]}}, p_reg};

    // Multiply stage, bias pick-up, and accumulate
    always_ff @(posedge clk)
    begin
        if (s1_valid_reg)
        begin
            p_reg <= PROD_W'($signed(a_rd)) * PROD_W'($signed(w_rd));
        end
        if (s1_valid_reg && s1_first_reg)
        begin
            init_reg <= bias_enable ? {{(ACC_W-BIAS_W){b_rd[BIAS_W-1]}}, b_rd} : '0;
        end
        if (s2_valid_reg)
        begin
            acc_reg <= s2_first_reg ? (init_reg + p_ext) : (acc_reg + p_ext);
        end
    end

    // Saturate to 32 bits: overflow when the top bits disagree with the sign
    always_comb
    begin
        if (acc_reg[ACC_W-1:RES_W-1] == '0 || acc_reg[ACC_W-1:RES_W-1] == '1)
            sat_value = acc_reg[RES_W-1:0];
        else if (acc_reg[ACC_W-1])
            sat_value = {1'b1, {(RES_W-1){1'b0}}};
        else
            sat_value = {1'b0, {(RES_W-1){1'b1}}};
    end

    // Output register
    assign out_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.result_load || cmd.err_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.result_load)
        begin
            out_row_reg    <= row[OUT_ROW_W-1:0];
            out_col_reg    <= j;
            out_result_reg <= sat_value;
            out_last_reg   <= cmd.result_last;
            out_status_reg <= STATUS_OK;
        end
        else if (cmd.err_load)
        begin
            out_row_reg    <= '0;
            out_col_reg    <= '0;
            out_result_reg <= '0;
            out_last_reg   <= 1'b1;
            out_status_reg <= STATUS_RANGE;
        end
    end

    assign sts.acc_ready = acc_ready_reg;
    assign sts.out_free  = out_free;

    assign out_valid  = out_valid_reg;
    assign out_row    = out_row_reg;
    assign out_col    = out_col_reg;
    assign out_result = out_result_reg;
    assign out_last   = out_last_reg;
    assign out_status = out_status_reg;

endmodule

// ===== sv/matrix_multiply_bias.sv =====
// A load beat is written to its store as it is accepted; an out-of-range compute enters the error state,
// and its error beat is registered once the output register is free.
// Each column runs in_width MACs through one shared multiply-accumulate unit, one per cycle,
// then passes the memory read, multiply and accumulate stages before its result is registered.
// One command beat is in flight at a time; the result register lets the next column proceed.
// Reset (rst_n, async low) clears control and sets registers to 1,1,1,0; stores are not cleared.
module matrix_multiply_bias
    import mmb_pkg::*;
#(
    parameter int MAX_ROWS = 16,
    parameter int MAX_IN   = 64,
    parameter int MAX_OUT  = 64
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    mmb_cmd_if.sink           cmd_ch,
    mmb_res_if.source         res_ch
);

    localparam int K_W = (MAX_IN > 1) ? $clog2(MAX_IN) : 1;

    cfg_t             cfg_reg, cfg_next;
    logic             cfg_wr;
    ctrl_cmd_t        cmd;
    dp_status_t       sts;
    logic [K_W-1:0]   k;
    logic [IDX_W-1:0] j;
    logic [IDX_W-1:0] row;

    // Configuration registers
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr)
        begin
            case (paddr[3:2])
                REG_ROW_COUNT:   cfg_next.row_count   = pwdata[ROWS_CFG_W-1:0];
                REG_IN_WIDTH:    cfg_next.in_width    = pwdata[DIM_CFG_W-1:0];
                REG_OUT_WIDTH:   cfg_next.out_width   = pwdata[DIM_CFG_W-1:0];
                REG_BIAS_ENABLE: cfg_next.bias_enable = pwdata[0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.row_count   <= ROWS_CFG_W'(1);
            cfg_reg.in_width    <= DIM_CFG_W'(1);
            cfg_reg.out_width   <= DIM_CFG_W'(1);
            cfg_reg.bias_enable <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Register read-back
    always_comb
    begin
        case (paddr[3:2])
            REG_ROW_COUNT:   prdata = APB_DW'(cfg_reg.row_count);
            REG_IN_WIDTH:    prdata = APB_DW'(cfg_reg.in_width);
            REG_OUT_WIDTH:   prdata = APB_DW'(cfg_reg.out_width);
            REG_BIAS_ENABLE: prdata = APB_DW'(cfg_reg.bias_enable);
            default:         prdata = '0;
        endcase
    end

    mmb_ctrl #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_IN   (MAX_IN),
        .MAX_OUT  (MAX_OUT),
        .K_W      (K_W)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .in_valid   (cmd_ch.valid),
        .in_ready   (cmd_ch.ready),
        .in_command (cmd_ch.command),
        .in_row     (cmd_ch.row_index),
        .sts        (sts),
        .cmd        (cmd),
        .k          (k),
        .j          (j),
        .row        (row)
    );

    mmb_dp #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_IN   (MAX_IN),
        .MAX_OUT  (MAX_OUT),
        .K_W      (K_W)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .k           (k),
        .j           (j),
        .row         (row),
        .bias_enable (cfg_reg.bias_enable),
        .in_row      (cmd_ch.row_index),
        .in_col      (cmd_ch.col_index),
        .in_element  (cmd_ch.element_value),
        .in_bias     (cmd_ch.bias_value),
        .sts         (sts),
        .out_valid   (res_ch.valid),
        .out_ready   (res_ch.ready),
        .out_row     (res_ch.out_row),
        .out_col     (res_ch.out_col),
        .out_result  (res_ch.result_value),
        .out_last    (res_ch.last),
        .out_status  (res_ch.status)
    );

endmodule

// ===== sv/mmb_checker.sv =====
// Port-level checks for the dense layer block, bound to the top level.
module mmb_checker
    import mmb_pkg::*;
(
    input logic                    clk,
    input logic                    rst_n,
    input logic                    in_valid,
    input logic                    in_ready,
    input logic [CMD_W-1:0]        in_command,
    input logic                    out_valid,
    input logic                    out_ready,
    input logic [OUT_ROW_W-1:0]    out_row,
    input logic [IDX_W-1:0]        out_col,
    input logic signed [RES_W-1:0] out_result,
    input logic                    out_last,
    input logic                    out_status
);

    // A compute beat holds off the command channel while it runs
    a_compute_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && in_command == CMD_COMPUTE |=> !in_ready)
        else $error("command channel ready right after a compute beat");

    // Loads leave the command channel ready
    a_load_single_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && in_command != CMD_COMPUTE |=> in_ready)
        else $error("command channel stalled after a load beat");

    // An error beat is the only beat of its compute and carries zeros
    a_error_beat: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_status == STATUS_RANGE |->
            out_last && out_result == 0 && out_col == 0 && out_row == 0)
        else $error("malformed error beat");

    // A stalled result beat holds
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=>
            out_valid && $stable(out_result) && $stable(out_col) && $stable(out_last))
        else $error("result beat changed while stalled");

endmodule

bind matrix_multiply_bias mmb_checker u_mmb_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (cmd_ch.valid),
    .in_ready   (cmd_ch.ready),
    .in_command (cmd_ch.command),
    .out_valid  (res_ch.valid),
    .out_ready  (res_ch.ready),
    .out_row    (res_ch.out_row),
    .out_col    (res_ch.out_col),
    .out_result (res_ch.result_value),
    .out_last   (res_ch.last),
    .out_status (res_ch.status)
);
